[hw/rtl/tpja_pkg.sv]
// Shared types, widths and the arctangent table for the joint angle pipeline.
package tpja_pkg;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ANGLE_BITS      = 14;

    localparam int ARM_BITS    = COORD_BITS + 1;          // arm component
    localparam int PROD_BITS   = 2 * ARM_BITS;            // one product
    localparam int NORM_BITS   = 2 * COORD_BITS + 2;      // |a|^2
    localparam int DOT_BITS    = 2 * COORD_BITS + 3;      // a.b, signed
    localparam int LEN_FRAC    = 20;
    localparam int SQ_IN_BITS  = NORM_BITS + LEN_FRAC;    // sqrt radicand
    localparam int LEN_BITS    = SQ_IN_BITS / 2;          // arm length
    localparam int DEN_BITS    = 2 * LEN_BITS;
    localparam int RATIO_FRAC  = 30;
    localparam int Q_BITS      = RATIO_FRAC + 1;          // cosine, Q30
    localparam int S_IN_BITS   = 2 * Q_BITS;              // 2^60 - q^2
    localparam int S_BITS      = S_IN_BITS / 2;           // sine, Q30
    localparam int ACC_FRAC    = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int CW          = 34;                      // CORDIC datapath
    localparam int ROUND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [CW-1:0] ACC_90  = 34'sd1509949440;
    localparam logic signed [CW-1:0] ACC_180 = 34'sd3019898880;
    localparam logic [CW-1:0]        ROUND_HALF = CW'(1) << (ROUND_SHIFT - 1);
    localparam logic [Q_BITS-1:0]    Q_ONE = Q_BITS'(1) << RATIO_FRAC;
    localparam logic [S_IN_BITS-1:0] Q_ONE_SQ = S_IN_BITS'(1) << (2 * RATIO_FRAC);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_x;
        logic signed [COORD_BITS-1:0] first_y;
        logic signed [COORD_BITS-1:0] first_z;
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic signed [COORD_BITS-1:0] vertex_z;
        logic signed [COORD_BITS-1:0] second_x;
        logic signed [COORD_BITS-1:0] second_y;
        logic signed [COORD_BITS-1:0] second_z;
    } tpja_pts_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] angle_deg;
        logic                  degenerate;
    } tpja_ang_t;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] t;
        case (idx)
            0:  t = 32'd754974720;
            1:  t = 32'd445687602;
            2:  t = 32'd235489089;
            3:  t = 32'd119537938;
            4:  t = 32'd60000934;
            5:  t = 32'd30029717;
            6:  t = 32'd15018523;
            7:  t = 32'd7509720;
            8:  t = 32'd3754917;
            9:  t = 32'd1877466;
            10: t = 32'd938734;
            11: t = 32'd469367;
            12: t = 32'd234684;
            13: t = 32'd117342;
            14: t = 32'd58671;
            15: t = 32'd29335;
            16: t = 32'd14668;
            17: t = 32'd7334;
            18: t = 32'd3667;
            19: t = 32'd1833;
            20: t = 32'd917;
            21: t = 32'd458;
            22: t = 32'd229;
            23: t = 32'd115;
            24: t = 32'd57;
            25: t = 32'd29;
            26: t = 32'd14;
            27: t = 32'd7;
            28: t = 32'd4;
            29: t = 32'd2;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/tpja_isqrt_step.sv]
// One registered digit step of a restoring integer square root.
module tpja_isqrt_step #(
    parameter int N    = 54,
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             en,
    input  logic [N-1:0]     v_prev,
    input  logic [N/2+2:0]   rem_prev,
    input  logic [N/2-1:0]   root_prev,
    output logic [N/2+2:0]   rem_reg,
    output logic [N/2-1:0]   root_reg,
    output logic [N-1:0]     v_reg
);
    localparam int R = N / 2;
    localparam int W = R + 3;

    logic [W-1:0] cur;
    logic [W-1:0] trial;
    logic         ge;
    logic [W-1:0] rem_next;
    logic [R-1:0] root_next;

    always_comb
    begin
        cur       = {rem_prev[W-3:0], v_prev[N-1-2*STEP -: 2]};
        trial     = {1'b0, root_prev, 2'b01};
        ge        = cur >= trial;
        rem_next  = ge ? cur - trial : cur;
        root_next = {root_prev[R-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            v_reg    <= v_prev;
        end
    end
endmodule

[hw/rtl/tpja_div_step.sv]
// One registered quotient bit of the cosine long division.
module tpja_div_step #(
    parameter int STEP = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [tpja_pkg::DEN_BITS-1:0] r_prev,
    input  logic [tpja_pkg::DEN_BITS-1:0] den_prev,
    input  logic [tpja_pkg::Q_BITS-1:0]   q_prev,
    output logic [tpja_pkg::DEN_BITS-1:0] r_reg,
    output logic [tpja_pkg::DEN_BITS-1:0] den_reg,
    output logic [tpja_pkg::Q_BITS-1:0]   q_reg
);
    import tpja_pkg::*;

    logic [DEN_BITS:0] cur;
    logic [DEN_BITS:0] diff;
    logic              ge;

    always_comb
    begin
        // integer bit first, then one fraction bit per step
        if (STEP == 0)
            cur = {1'b0, r_prev};
        else
            cur = {r_prev, 1'b0};
        diff = cur - {1'b0, den_prev};
        ge   = cur >= {1'b0, den_prev};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= ge ? diff[DEN_BITS-1:0] : cur[DEN_BITS-1:0];
            den_reg <= den_prev;
            q_reg   <= {q_prev[Q_BITS-2:0], ge};
        end
    end
endmodule

[hw/rtl/tpja_cordic_step.sv]
// One registered CORDIC vectoring micro-rotation with angle accumulation.
module tpja_cordic_step #(
    parameter int STEP = 0
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [tpja_pkg::CW-1:0] x_prev,
    input  logic signed [tpja_pkg::CW-1:0] y_prev,
    input  logic signed [tpja_pkg::CW-1:0] acc_prev,
    output logic signed [tpja_pkg::CW-1:0] x_reg,
    output logic signed [tpja_pkg::CW-1:0] y_reg,
    output logic signed [tpja_pkg::CW-1:0] acc_reg
);
    import tpja_pkg::*;

    localparam logic signed [CW-1:0] ANG = $signed({2'b00, atan_entry(STEP)});

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic                 pos;

    always_comb
    begin
        xs  = x_prev >>> STEP;
        ys  = y_prev >>> STEP;
        pos = !y_prev[CW-1] && (y_prev != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= pos ? x_prev + ys : x_prev - ys;
            y_reg   <= pos ? y_prev - xs : y_prev + xs;
            acc_reg <= pos ? acc_prev + ANG : acc_prev - ANG;
        end
    end
endmodule

[hw/rtl/three_point_joint_angle_top.sv]
// Top level of the three point joint angle pipeline.
// Takes one request of three 3D points (first, vertex, second) per cycle while pts_stall
// is low and returns the angle at the vertex in 1/64 degree, 0..11520, plus a degenerate
// flag when either arm has zero length (angle then 0). The pipeline has 125 register
// stages up to and including the result register: 3 front stages (arm differences,
// products, sums), 27 stages of arm length square roots, a 27x27 multiply stage, 31
// stages of long division for the cosine, a clamp and square stage, 31 stages of sine
// square root, 30 CORDIC stages and a final clamp and round stage. One output register
// follows. Throughput is one request per cycle while pts_stall is low. The whole
// pipeline advances together; an output register plus a one-entry skid register decouple
// it from the result side, so requests are still taken while a finished result waits,
// until one more result fills the skid entry; pts_stall rises only when the skid entry is
// occupied. pts_stall is a pure register output and never looks at pts_valid.
module three_point_joint_angle_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pts_valid,
    output logic               pts_stall,
    input  tpja_pkg::tpja_pts_t pts,
    output logic               ang_valid,
    input  logic               ang_stall,
    output tpja_pkg::tpja_ang_t ang
);
    import tpja_pkg::*;

    localparam int SEG_A = LEN_BITS;
    localparam int SEG_B = Q_BITS;
    localparam int SEG_C = S_BITS;
    localparam int SEG_D = CORDIC_STEPS;
    localparam int DEPTH = 3 + SEG_A + 1 + SEG_B + 1 + SEG_C + SEG_D + 1;

    typedef struct packed {
        logic signed [DOT_BITS-1:0] dot;
        logic                       deg;
    } sb_a_t;

    typedef struct packed {
        logic neg;
        logic deg;
    } sb_b_t;

    typedef struct packed {
        logic [Q_BITS-1:0] q;
        logic              neg;
        logic              deg;
    } sb_c_t;

    // pipeline control: everything moves unless the skid entry is full
    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic             out_vld_reg;
    logic             skid_vld_reg;
    logic             take;
    tpja_ang_t        out_reg;
    tpja_ang_t        skid_reg;
    tpja_ang_t        res_reg;

    assign en        = !skid_vld_reg;
    assign pts_stall = skid_vld_reg;
    assign ang_valid = out_vld_reg;
    assign ang       = out_reg;
    assign take      = out_vld_reg && !ang_stall;

    // front: arms, products, sums
    logic signed [ARM_BITS-1:0]  da_reg [3];
    logic signed [ARM_BITS-1:0]  db_reg [3];
    logic signed [PROD_BITS-1:0] sqa_reg [3];
    logic signed [PROD_BITS-1:0] sqb_reg [3];
    logic signed [PROD_BITS-1:0] dp_reg [3];
    logic                        deg2_reg;
    logic [NORM_BITS-1:0]        na_reg;
    logic [NORM_BITS-1:0]        nb_reg;
    logic signed [DOT_BITS-1:0]  dot_reg;
    logic                        deg3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            da_reg[0] <= ARM_BITS'(pts.first_x) - ARM_BITS'(pts.vertex_x);
            da_reg[1] <= ARM_BITS'(pts.first_y) - ARM_BITS'(pts.vertex_y);
            da_reg[2] <= ARM_BITS'(pts.first_z) - ARM_BITS'(pts.vertex_z);
            db_reg[0] <= ARM_BITS'(pts.second_x) - ARM_BITS'(pts.vertex_x);
            db_reg[1] <= ARM_BITS'(pts.second_y) - ARM_BITS'(pts.vertex_y);
            db_reg[2] <= ARM_BITS'(pts.second_z) - ARM_BITS'(pts.vertex_z);
            for (int k = 0; k < 3; k++)
            begin
                sqa_reg[k] <= PROD_BITS'(da_reg[k]) * PROD_BITS'(da_reg[k]);
                sqb_reg[k] <= PROD_BITS'(db_reg[k]) * PROD_BITS'(db_reg[k]);
                dp_reg[k]  <= PROD_BITS'(da_reg[k]) * PROD_BITS'(db_reg[k]);
            end
            deg2_reg <= (da_reg[0] == '0 && da_reg[1] == '0 && da_reg[2] == '0) ||
                        (db_reg[0] == '0 && db_reg[1] == '0 && db_reg[2] == '0);
            na_reg   <= NORM_BITS'($unsigned(sqa_reg[0])) + NORM_BITS'($unsigned(sqa_reg[1]))
                      + NORM_BITS'($unsigned(sqa_reg[2]));
            nb_reg   <= NORM_BITS'($unsigned(sqb_reg[0])) + NORM_BITS'($unsigned(sqb_reg[1]))
                      + NORM_BITS'($unsigned(sqb_reg[2]));
            dot_reg  <= DOT_BITS'(dp_reg[0]) + DOT_BITS'(dp_reg[1]) + DOT_BITS'(dp_reg[2]);
            deg3_reg <= deg2_reg;
        end
    end

    // arm lengths: floor(sqrt(n * 2^20)), one root bit per stage
    logic [SQ_IN_BITS-1:0] av [SEG_A+1];
    logic [LEN_BITS+2:0]   arem [SEG_A+1];
    logic [LEN_BITS-1:0]   aroot [SEG_A+1];
    logic [SQ_IN_BITS-1:0] bv [SEG_A+1];
    logic [LEN_BITS+2:0]   brem [SEG_A+1];
    logic [LEN_BITS-1:0]   broot [SEG_A+1];
    sb_a_t                 sba_reg [SEG_A];

    assign av[0]    = {na_reg, {LEN_FRAC{1'b0}}};
    assign arem[0]  = '0;
    assign aroot[0] = '0;
    assign bv[0]    = {nb_reg, {LEN_FRAC{1'b0}}};
    assign brem[0]  = '0;
    assign broot[0] = '0;

    for (genvar i = 0; i < SEG_A; i++)
    begin : g_len
        tpja_isqrt_step #(.N(SQ_IN_BITS), .STEP(i)) u_sqa (
            .clk(clk), .en(en),
            .v_prev(av[i]), .rem_prev(arem[i]), .root_prev(aroot[i]),
            .rem_reg(arem[i+1]), .root_reg(aroot[i+1]), .v_reg(av[i+1])
        );
        tpja_isqrt_step #(.N(SQ_IN_BITS), .STEP(i)) u_sqb (
            .clk(clk), .en(en),
            .v_prev(bv[i]), .rem_prev(brem[i]), .root_prev(broot[i]),
            .rem_reg(brem[i+1]), .root_reg(broot[i+1]), .v_reg(bv[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sba_reg[0] <= '{dot: dot_reg, deg: deg3_reg};
            for (int i = 1; i < SEG_A; i++)
                sba_reg[i] <= sba_reg[i-1];
        end
    end

    // denominator la*lb and numerator |dot| * 2^20
    logic [DEN_BITS-1:0]        den_reg;
    logic [DEN_BITS-1:0]        num_reg;
    logic                       neg_reg;
    logic                       deg4_reg;
    logic signed [DOT_BITS-1:0] dot_mag;

    assign dot_mag = sba_reg[SEG_A-1].dot[DOT_BITS-1] ? -sba_reg[SEG_A-1].dot
                                                      : sba_reg[SEG_A-1].dot;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= DEN_BITS'(aroot[SEG_A]) * DEN_BITS'(broot[SEG_A]);
            num_reg  <= {dot_mag[DEN_BITS-LEN_FRAC-1:0], {LEN_FRAC{1'b0}}};
            neg_reg  <= sba_reg[SEG_A-1].dot[DOT_BITS-1];
            deg4_reg <= sba_reg[SEG_A-1].deg;
        end
    end

    // cosine magnitude q in Q30, one quotient bit per stage
    logic [DEN_BITS-1:0] dr [SEG_B+1];
    logic [DEN_BITS-1:0] dd [SEG_B+1];
    logic [Q_BITS-1:0]   dq [SEG_B+1];
    sb_b_t               sbb_reg [SEG_B];

    assign dr[0] = num_reg;
    assign dd[0] = den_reg;
    assign dq[0] = '0;

    for (genvar i = 0; i < SEG_B; i++)
    begin : g_div
        tpja_div_step #(.STEP(i)) u_div (
            .clk(clk), .en(en),
            .r_prev(dr[i]), .den_prev(dd[i]), .q_prev(dq[i]),
            .r_reg(dr[i+1]), .den_reg(dd[i+1]), .q_reg(dq[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sbb_reg[0] <= '{neg: neg_reg, deg: deg4_reg};
            for (int i = 1; i < SEG_B; i++)
                sbb_reg[i] <= sbb_reg[i-1];
        end
    end

    // clamp q to one and square it
    logic [Q_BITS-1:0]    qc;
    logic [Q_BITS-1:0]    qc_reg;
    logic [S_IN_BITS-1:0] qsq_reg;
    logic                 neg5_reg;
    logic                 deg5_reg;

    assign qc = (dq[SEG_B] > Q_ONE) ? Q_ONE : dq[SEG_B];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qc_reg   <= qc;
            qsq_reg  <= S_IN_BITS'(qc) * S_IN_BITS'(qc);
            neg5_reg <= sbb_reg[SEG_B-1].neg;
            deg5_reg <= sbb_reg[SEG_B-1].deg;
        end
    end

    // sine s = floor(sqrt(2^60 - q^2))
    logic [S_IN_BITS-1:0] sv [SEG_C+1];
    logic [S_BITS+2:0]    srem [SEG_C+1];
    logic [S_BITS-1:0]    sroot [SEG_C+1];
    sb_c_t                sbc_reg [SEG_C];

    assign sv[0]    = Q_ONE_SQ - qsq_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;

    for (genvar i = 0; i < SEG_C; i++)
    begin : g_sin
        tpja_isqrt_step #(.N(S_IN_BITS), .STEP(i)) u_sqs (
            .clk(clk), .en(en),
            .v_prev(sv[i]), .rem_prev(srem[i]), .root_prev(sroot[i]),
            .rem_reg(srem[i+1]), .root_reg(sroot[i+1]), .v_reg(sv[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sbc_reg[0] <= '{q: qc_reg, neg: neg5_reg, deg: deg5_reg};
            for (int i = 1; i < SEG_C; i++)
                sbc_reg[i] <= sbc_reg[i-1];
        end
    end

    // CORDIC vectoring; obtuse angles start from 90 degrees with swapped inputs
    logic signed [CW-1:0] cx [SEG_D+1];
    logic signed [CW-1:0] cy [SEG_D+1];
    logic signed [CW-1:0] cacc [SEG_D+1];
    logic                 sbd_reg [SEG_D];
    logic signed [CW-1:0] qv;
    logic signed [CW-1:0] s_val;

    assign qv      = $signed(CW'(sbc_reg[SEG_C-1].q));
    assign s_val   = $signed(CW'(sroot[SEG_C]));
    assign cx[0]   = sbc_reg[SEG_C-1].neg ? s_val : qv;
    assign cy[0]   = sbc_reg[SEG_C-1].neg ? qv : s_val;
    assign cacc[0] = sbc_reg[SEG_C-1].neg ? ACC_90 : '0;

    for (genvar i = 0; i < SEG_D; i++)
    begin : g_cordic
        tpja_cordic_step #(.STEP(i)) u_rot (
            .clk(clk), .en(en),
            .x_prev(cx[i]), .y_prev(cy[i]), .acc_prev(cacc[i]),
            .x_reg(cx[i+1]), .y_reg(cy[i+1]), .acc_reg(cacc[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sbd_reg[0] <= sbc_reg[SEG_C-1].deg;
            for (int i = 1; i < SEG_D; i++)
                sbd_reg[i] <= sbd_reg[i-1];
        end
    end

    // clamp to [0, 180] degrees, round half up to 1/64 degree
    logic signed [CW-1:0] acc_cl;
    logic [CW-1:0]        acc_rnd;

    always_comb
    begin
        if (cacc[SEG_D][CW-1])
            acc_cl = '0;
        else if (cacc[SEG_D] > ACC_180)
            acc_cl = ACC_180;
        else
            acc_cl = cacc[SEG_D];
        acc_rnd = $unsigned(acc_cl) + ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.angle_deg  <= sbd_reg[SEG_D-1] ? '0 : acc_rnd[ROUND_SHIFT +: ANGLE_BITS];
            res_reg.degenerate <= sbd_reg[SEG_D-1];
        end
    end

    // valid bits and output/skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (en)
                vld_reg <= {vld_reg[DEPTH-2:0], pts_valid};
            if (skid_vld_reg)
            begin
                if (take)
                    skid_vld_reg <= 1'b0;
            end
            else if (vld_reg[DEPTH-1])
            begin
                if (out_vld_reg && !take)
                    skid_vld_reg <= 1'b1;
                else
                    out_vld_reg <= 1'b1;
            end
            else if (take)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (vld_reg[DEPTH-1])
        begin
            if (out_vld_reg && !take)
                skid_reg <= res_reg;
            else
                out_reg <= res_reg;
        end
    end
endmodule

[hw/rtl/tpja_checker.sv]
// Port-level checks for the joint angle block, bound to the top level.
module tpja_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pts_valid,
    input logic                pts_stall,
    input tpja_pkg::tpja_pts_t pts,
    input logic                ang_valid,
    input logic                ang_stall,
    input tpja_pkg::tpja_ang_t ang
);
    import tpja_pkg::*;

    // stalled result is held
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ang_valid && ang_stall |=> ang_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        ang_valid && ang_stall |=> $stable(ang))
        else $error("result changed while stalled");

    // zero-length arm reports zero angle
    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        ang_valid && ang.degenerate |-> ang.angle_deg == '0)
        else $error("degenerate result with nonzero angle");

    // request side backs up only after the result side held off
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pts_stall |-> $past(ang_valid && ang_stall))
        else $error("request stall without result stall");

endmodule

bind three_point_joint_angle_top tpja_checker u_tpja_checker (.*);
